@@ rtl/twd_pkg.sv @@
package twd_pkg;

    // Channel and table sizing
    localparam int NUM_CHANNELS     = 2;
    localparam int TANH_TABLE_DEPTH = 256;   // power of two, 64 to 4096
    localparam int CH_IDX_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TBL_LOG2         = $clog2(TANH_TABLE_DEPTH);
    localparam int TI_W             = TBL_LOG2 + 1;        // addresses 0..depth
    localparam int MAG_W            = 28;                  // |sample * drive|
    localparam int FRAC_W           = 25 - TBL_LOG2;       // interpolation fraction
    localparam int IDX_FULL_W       = MAG_W - FRAC_W;

    // Datapath widths
    localparam int SAMPLE_W = 16;
    localparam int DRIVE_W  = 13;
    localparam int CTRL_W   = 16;
    localparam int SAT_W    = 17;    // Q1.15 control after clamping to 32768
    localparam int LP_W     = 24;    // Q1.23 filter state
    localparam int TONED_W  = 26;
    localparam int WET_W    = 20;
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 18;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    // Register file
    localparam int NUM_REGS   = 5;
    localparam int ADDR_W     = $clog2(4 * NUM_REGS);
    localparam int APB_DATA_W = 32;

    localparam logic [DRIVE_W-1:0] DRIVE_RST = 13'd256;
    localparam logic [CTRL_W-1:0]  TONE_RST  = 16'd16384;
    localparam logic [CTRL_W-1:0]  MIX_RST   = 16'd32768;
    localparam logic [CTRL_W-1:0]  GAIN_RST  = 16'd16384;
    localparam logic [CTRL_W-1:0]  COEFF_RST = 16'd52000;
    localparam logic [SAT_W-1:0]   Q15_ONE   = 17'd32768;

    typedef enum logic [2:0] {
        REG_DRIVE_GAIN    = 3'd0,
        REG_TONE_BLEND    = 3'd1,
        REG_WET_DRY_MIX   = 3'd2,
        REG_OUTPUT_GAIN   = 3'd3,
        REG_LOWPASS_COEFF = 3'd4
    } twd_reg_idx_t;

    // Controls as the datapath sees them (Q1.15 controls already clamped)
    typedef struct packed {
        logic [DRIVE_W-1:0] drive_gain;
        logic [SAT_W-1:0]   tone_blend;
        logic [SAT_W-1:0]   wet_dry_mix;
        logic [SAT_W-1:0]   output_gain;
        logic [CTRL_W-1:0]  lowpass_coeff;
    } twd_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DRIVE,
        ST_CLIP,
        ST_MUL_INTERP,
        ST_SHAPE,
        ST_MUL_LP,
        ST_LOWPASS,
        ST_MUL_TONE,
        ST_TONE,
        ST_MUL_GAIN,
        ST_GAIN,
        ST_MUL_MIX,
        ST_MIX
    } twd_state_t;

    typedef enum logic [2:0] {
        MOP_DRIVE,
        MOP_INTERP,
        MOP_LP,
        MOP_TONE,
        MOP_GAIN,
        MOP_MIX
    } twd_mul_op_t;

    typedef enum logic [2:0] {
        POP_NONE,
        POP_CLIP,
        POP_SHAPE,
        POP_LOWPASS,
        POP_TONE,
        POP_GAIN,
        POP_MIX
    } twd_post_op_t;

    typedef struct packed {
        logic         load_in;
        logic         mul_en;
        twd_mul_op_t  mul_op;
        twd_post_op_t post_op;
    } twd_cmd_t;

    typedef struct packed {
        logic out_free;
    } twd_status_t;

    typedef logic [TANH_TABLE_DEPTH:0][SAMPLE_W-1:0] tanh_rom_t;

    // Restoring long division, evaluated only while the table is built
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(4k/depth) in Q1.15 via (1 - e^-2x) / (1 + e^-2x), Q30 integer math
    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t   rom;
        logic [63:0] one;
        logic [63:0] u;
        logic [63:0] e;
        logic [63:0] term;
        logic [63:0] m;
        logic [63:0] q;
        int          k;
        int          j;
        int          r;
        one = 64'd1 << 30;
        for (k = 0; k <= TANH_TABLE_DEPTH; k++) begin
            u    = (64'(k) << 30) >> TBL_LOG2;
            e    = one;
            term = one;
            for (j = 1; j <= 14; j++) begin
                term = div_u64((term * u) >> 30, 64'(j));
                e    = e + term;
            end
            m = div_u64((64'd1 << 60) + (e >> 1), e);
            for (r = 0; r < 3; r++) begin
                m = (m * m + (64'd1 << 29)) >> 30;
            end
            if (m > one) begin
                m = one;
            end
            q = div_u64(((one - m) << 15) + ((one + m) >> 1), one + m);
            if (q > 64'd32767) begin
                q = 64'd32767;
            end
            rom[k] = q[SAMPLE_W-1:0];
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

@@ rtl/tanh_waveshaper_distortion.sv @@
// Tanh soft-clip distortion for Q1.15 audio. Each input beat carries one sample and a
// channel select; the sample is scaled by drive_gain, soft-clipped through an
// interpolated tanh table, filtered by that channel's one-pole lowpass, crossfaded
// between lowpass and highpass by tone_blend, scaled by output_gain, mixed against
// the dry sample by wet_dry_mix and returned saturated to 16 bits, one output beat
// per input beat, in order. Each sample passes from acceptance to the result
// register through one accept step and six multiply/post-process pairs, all
// sequenced through a single shared 26x18 multiplier, so a new sample is taken
// only once the last one has finished its sequence. The output register frees
// the input side: the next sample is accepted while the previous result still waits
// for m_tready, and the engine stalls only at its last step if that result is still
// unclaimed. Both filter states are cleared by reset. Registers sit on the APB port
// at byte offsets 0x00 drive_gain, 0x04 tone_blend, 0x08 wet_dry_mix, 0x0C
// output_gain, 0x10 lowpass_coeff; write them only while no sample is in flight.
module tanh_waveshaper_distortion (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,    // [15:0] sample_in
    input  logic                             s_tuser,    // [0] chan
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,    // [15:0] sample_out
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [twd_pkg::ADDR_W-1:0]       paddr,
    input  logic [twd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [twd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import twd_pkg::*;

    twd_cfg_t    cfg;
    twd_cmd_t    cmd;
    twd_status_t status;

    // Register file: holds raw settings, presents clamped controls
    twd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    // Sequencer: steps one sample through the shared multiplier
    twd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_tvalid),
        .s_ready_o (s_tready),
        .status_i  (status),
        .cmd_o     (cmd)
    );

    // Datapath: multiplier, tanh table, filter state and result register
    twd_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_i       (cmd),
        .status_o    (status),
        .cfg_i       (cfg),
        .chan_i      (s_tuser),
        .sample_i    (s_tdata),
        .out_valid_o (m_tvalid),
        .out_data_o  (m_tdata),
        .out_ready_i (m_tready)
    );

endmodule

@@ rtl/twd_regs.sv @@
module twd_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [twd_pkg::ADDR_W-1:0]       paddr,
    input  logic [twd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [twd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output twd_pkg::twd_cfg_t                cfg_o
);
    import twd_pkg::*;

    logic [DRIVE_W-1:0] drive_reg;
    logic [CTRL_W-1:0]  tone_reg;
    logic [CTRL_W-1:0]  mix_reg;
    logic [CTRL_W-1:0]  gain_reg;
    logic [CTRL_W-1:0]  coeff_reg;
    logic               wr_en;
    twd_reg_idx_t       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = twd_reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= DRIVE_RST;
            tone_reg  <= TONE_RST;
            mix_reg   <= MIX_RST;
            gain_reg  <= GAIN_RST;
            coeff_reg <= COEFF_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DRIVE_GAIN:    drive_reg <= pwdata[DRIVE_W-1:0];
                REG_TONE_BLEND:    tone_reg  <= pwdata[CTRL_W-1:0];
                REG_WET_DRY_MIX:   mix_reg   <= pwdata[CTRL_W-1:0];
                REG_OUTPUT_GAIN:   gain_reg  <= pwdata[CTRL_W-1:0];
                REG_LOWPASS_COEFF: coeff_reg <= pwdata[CTRL_W-1:0];
                default: ;   // unmapped index: drop the write
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DRIVE_GAIN:    prdata = APB_DATA_W'(drive_reg);
            REG_TONE_BLEND:    prdata = APB_DATA_W'(tone_reg);
            REG_WET_DRY_MIX:   prdata = APB_DATA_W'(mix_reg);
            REG_OUTPUT_GAIN:   prdata = APB_DATA_W'(gain_reg);
            REG_LOWPASS_COEFF: prdata = APB_DATA_W'(coeff_reg);
            default:           prdata = '0;
        endcase
    end

    // Clamp Q1.15 controls to unity
    always_comb begin
        cfg_o.drive_gain    = drive_reg;
        cfg_o.tone_blend    = (SAT_W'(tone_reg) > Q15_ONE) ? Q15_ONE : SAT_W'(tone_reg);
        cfg_o.wet_dry_mix   = (SAT_W'(mix_reg) > Q15_ONE) ? Q15_ONE : SAT_W'(mix_reg);
        cfg_o.output_gain   = (SAT_W'(gain_reg) > Q15_ONE) ? Q15_ONE : SAT_W'(gain_reg);
        cfg_o.lowpass_coeff = coeff_reg;
    end

endmodule

@@ rtl/twd_ctrl.sv @@
module twd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid_i,
    output logic                 s_ready_o,
    input  twd_pkg::twd_status_t status_i,
    output twd_pkg::twd_cmd_t    cmd_o
);
    import twd_pkg::*;

    twd_state_t state_reg;
    twd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid_i) begin
                    state_next = ST_MUL_DRIVE;
                end
            end
            ST_MUL_DRIVE:  state_next = ST_CLIP;
            ST_CLIP:       state_next = ST_MUL_INTERP;
            ST_MUL_INTERP: state_next = ST_SHAPE;
            ST_SHAPE:      state_next = ST_MUL_LP;
            ST_MUL_LP:     state_next = ST_LOWPASS;
            ST_LOWPASS:    state_next = ST_MUL_TONE;
            ST_MUL_TONE:   state_next = ST_TONE;
            ST_TONE:       state_next = ST_MUL_GAIN;
            ST_MUL_GAIN:   state_next = ST_GAIN;
            ST_GAIN:       state_next = ST_MUL_MIX;
            ST_MUL_MIX:    state_next = ST_MIX;
            ST_MIX: begin
                if (status_i.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready_o     = 1'b0;
        cmd_o.load_in = 1'b0;
        cmd_o.mul_en  = 1'b0;
        cmd_o.mul_op  = MOP_DRIVE;
        cmd_o.post_op = POP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready_o     = 1'b1;
                cmd_o.load_in = s_valid_i;
            end
            ST_MUL_DRIVE: begin
                cmd_o.mul_en = 1'b1;
                cmd_o.mul_op = MOP_DRIVE;
            end
            ST_CLIP:       cmd_o.post_op = POP_CLIP;
            ST_MUL_INTERP: begin
                cmd_o.mul_en = 1'b1;
                cmd_o.mul_op = MOP_INTERP;
            end
            ST_SHAPE:      cmd_o.post_op = POP_SHAPE;
            ST_MUL_LP: begin
                cmd_o.mul_en = 1'b1;
                cmd_o.mul_op = MOP_LP;
            end
            ST_LOWPASS:    cmd_o.post_op = POP_LOWPASS;
            ST_MUL_TONE: begin
                cmd_o.mul_en = 1'b1;
                cmd_o.mul_op = MOP_TONE;
            end
            ST_TONE:       cmd_o.post_op = POP_TONE;
            ST_MUL_GAIN: begin
                cmd_o.mul_en = 1'b1;
                cmd_o.mul_op = MOP_GAIN;
            end
            ST_GAIN:       cmd_o.post_op = POP_GAIN;
            ST_MUL_MIX: begin
                cmd_o.mul_en = 1'b1;
                cmd_o.mul_op = MOP_MIX;
            end
            ST_MIX: begin
                // hold the final step until the output register can take it
                if (status_i.out_free) begin
                    cmd_o.post_op = POP_MIX;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/twd_dp.sv @@
module twd_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  twd_pkg::twd_cmd_t            cmd_i,
    output twd_pkg::twd_status_t         status_o,
    input  twd_pkg::twd_cfg_t            cfg_i,
    input  logic                         chan_i,
    input  logic [twd_pkg::SAMPLE_W-1:0] sample_i,
    output logic                         out_valid_o,
    output logic [twd_pkg::SAMPLE_W-1:0] out_data_o,
    input  logic                         out_ready_i
);
    import twd_pkg::*;

    localparam logic signed [MUL_P_W-1:0] RND_SHAPE = MUL_P_W'(1) << (FRAC_W - 1);
    localparam logic signed [MUL_P_W-1:0] RND_16    = MUL_P_W'(1) << 15;
    localparam logic signed [MUL_P_W-1:0] RND_15    = MUL_P_W'(1) << 14;
    localparam logic signed [MUL_P_W-1:0] RND_22    = MUL_P_W'(1) << 21;
    localparam int                        MIX_W     = 29;
    localparam logic signed [MIX_W-1:0]   SAT_HI    = 29'sd32767;
    localparam logic signed [MIX_W-1:0]   SAT_LO    = -29'sd32768;

    // Item and intermediate registers
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [CH_IDX_W-1:0]        ch_reg;
    logic signed [MUL_P_W-1:0]  prod_reg;
    logic                       sign_reg;
    logic [SAMPLE_W-2:0]        base_reg;
    logic signed [SAMPLE_W:0]   delta_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic signed [LP_W-1:0]     s_reg;
    logic signed [LP_W-1:0]     lp_reg;
    logic signed [TONED_W-1:0]  toned_reg;
    logic signed [WET_W-1:0]    wet_reg;
    logic signed [LP_W-1:0]     lp_mem_reg [NUM_CHANNELS];
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;

    logic [CH_IDX_W-1:0]        ch_next;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod_next;

    logic signed [MAG_W:0]      p_val;
    logic                       p_neg;
    logic signed [MAG_W:0]      p_abs;
    logic [MAG_W-1:0]           mag;
    logic [IDX_FULL_W-1:0]      idx_full;
    logic                       clip_sat;
    logic [TI_W-1:0]            tbl_idx;
    logic [TI_W-1:0]            tbl_idx_hi;
    logic [SAMPLE_W-1:0]        tbl_lo;
    logic [SAMPLE_W-1:0]        tbl_hi;
    logic [SAMPLE_W-2:0]        base_next;
    logic signed [SAMPLE_W:0]   delta_next;
    logic [FRAC_W-1:0]          frac_next;

    logic signed [MUL_P_W-1:0]  shape_sum;
    logic [SAMPLE_W-2:0]        shape_mag;
    logic signed [SAMPLE_W-1:0] shaped;
    logic signed [LP_W-1:0]     s_next;
    logic signed [MUL_P_W-1:0]  lp_sum;
    logic signed [LP_W-1:0]     lp_next;
    logic signed [MUL_P_W-1:0]  tone_sum;
    logic signed [TONED_W-1:0]  toned_next;
    logic signed [MUL_P_W-1:0]  gain_sum;
    logic signed [WET_W-1:0]    wet_next;
    logic signed [MUL_P_W-1:0]  mix_sum;
    logic signed [MIX_W-1:0]    mix_full;
    logic [SAMPLE_W-1:0]        out_data_next;

    // Out-of-range channels fold onto the last filter state
    assign ch_next = (int'(chan_i) >= NUM_CHANNELS) ? CH_IDX_W'(NUM_CHANNELS - 1)
                                                     : CH_IDX_W'(chan_i);

    // Shared multiplier operand select
    always_comb begin
        case (cmd_i.mul_op)
            MOP_DRIVE: begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = $signed(MUL_B_W'(cfg_i.drive_gain));
            end
            MOP_INTERP: begin
                mul_a = $signed(MUL_A_W'(frac_reg));
                mul_b = MUL_B_W'(delta_reg);
            end
            MOP_LP: begin
                mul_a = MUL_A_W'(lp_mem_reg[ch_reg]) - MUL_A_W'(s_reg);
                mul_b = $signed(MUL_B_W'(cfg_i.lowpass_coeff));
            end
            MOP_TONE: begin
                mul_a = MUL_A_W'(s_reg) - (MUL_A_W'(lp_reg) <<< 1);
                mul_b = $signed(MUL_B_W'(cfg_i.tone_blend));
            end
            MOP_GAIN: begin
                mul_a = toned_reg;
                mul_b = $signed(MUL_B_W'(cfg_i.output_gain));
            end
            MOP_MIX: begin
                mul_a = MUL_A_W'(wet_reg) - MUL_A_W'(x_reg);
                mul_b = $signed(MUL_B_W'(cfg_i.wet_dry_mix));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Clip step: magnitude, table address and interpolation fraction
    always_comb begin
        p_val      = $signed(prod_reg[MAG_W:0]);
        p_neg      = p_val[MAG_W];
        p_abs      = p_neg ? -p_val : p_val;
        mag        = p_abs[MAG_W-1:0];
        idx_full   = mag[MAG_W-1:FRAC_W];
        clip_sat   = |idx_full[IDX_FULL_W-1:TBL_LOG2];
        tbl_idx    = {1'b0, idx_full[TBL_LOG2-1:0]};
        tbl_idx_hi = tbl_idx + TI_W'(1);
        tbl_lo     = TANH_ROM[tbl_idx];
        tbl_hi     = TANH_ROM[tbl_idx_hi];
        if (clip_sat) begin
            base_next  = TANH_ROM[TANH_TABLE_DEPTH][SAMPLE_W-2:0];
            delta_next = '0;
            frac_next  = '0;
        end else begin
            base_next  = tbl_lo[SAMPLE_W-2:0];
            delta_next = $signed({1'b0, tbl_hi}) - $signed({1'b0, tbl_lo});
            frac_next  = mag[FRAC_W-1:0];
        end
    end

    // Post-multiply steps: each adds and takes a fixed shift; shape restores the sign, mix saturates
    always_comb begin
        shape_sum  = ($signed(MUL_P_W'(base_reg)) <<< FRAC_W) + prod_reg + RND_SHAPE;
        shape_mag  = shape_sum[FRAC_W +: (SAMPLE_W - 1)];
        shaped     = sign_reg ? -$signed({1'b0, shape_mag}) : $signed({1'b0, shape_mag});
        s_next     = $signed({shaped, 8'd0});

        lp_sum     = (MUL_P_W'(s_reg) <<< 16) + prod_reg + RND_16;
        lp_next    = $signed(lp_sum[16 +: LP_W]);

        tone_sum   = (MUL_P_W'(lp_reg) <<< 15) + prod_reg + RND_15;
        toned_next = $signed(tone_sum[15 +: TONED_W]);

        gain_sum   = prod_reg + RND_22;
        wet_next   = $signed(gain_sum[22 +: WET_W]);

        mix_sum    = (MUL_P_W'(x_reg) <<< 15) + prod_reg + RND_15;
        mix_full   = $signed(mix_sum[15 +: MIX_W]);
        if (mix_full > SAT_HI) begin
            out_data_next = 16'h7FFF;
        end else if (mix_full < SAT_LO) begin
            out_data_next = 16'h8000;
        end else begin
            out_data_next = mix_full[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_in) begin
            x_reg  <= $signed(sample_i);
            ch_reg <= ch_next;
        end
        if (cmd_i.mul_en) begin
            prod_reg <= prod_next;
        end
        case (cmd_i.post_op)
            POP_CLIP: begin
                sign_reg  <= p_neg;
                base_reg  <= base_next;
                delta_reg <= delta_next;
                frac_reg  <= frac_next;
            end
            POP_SHAPE:   s_reg     <= s_next;
            POP_LOWPASS: lp_reg    <= lp_next;
            POP_TONE:    toned_reg <= toned_next;
            POP_GAIN:    wet_reg   <= wet_next;
            POP_MIX:     out_data_reg <= out_data_next;
            default: ;
        endcase
    end

    // Per-channel filter state, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                lp_mem_reg[i] <= '0;
            end
        end else if (cmd_i.post_op == POP_LOWPASS) begin
            lp_mem_reg[ch_reg] <= lp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd_i.post_op == POP_MIX) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready_i) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status_o.out_free = !out_valid_reg || out_ready_i;
    assign out_valid_o       = out_valid_reg;
    assign out_data_o        = out_data_reg;

endmodule

@@ rtl/twd_checker.sv @@
module twd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // coming out of reset: nothing to deliver, ready for input
    a_reset_state: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // one sample in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample accepted while busy");

    // no result rises right after a sample is accepted
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after accept");

    // a new result coincides with the engine going idle
    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result presented while engine still busy");

endmodule

bind tanh_waveshaper_distortion twd_checker u_twd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
